// File: hw/rtl/rv32i_integer_execute_step_top_assert.svh
// Assertion macros for the execute step checker.
// Used by rvx_checker only; no other dependencies.
`ifndef RV32I_INTEGER_EXECUTE_STEP_TOP_ASSERT_SVH
`define RV32I_INTEGER_EXECUTE_STEP_TOP_ASSERT_SVH

// same-cycle implication
`define RVX_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RVX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/rvx_pkg.sv
// Shared types and constants for the RV32I execute step.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rvx_pkg;

   localparam int RVX_REGISTER_COUNT = 32;
   localparam int RVX_XLEN           = 32;
   localparam int RVX_REG_ADDR_W     = 5;

   // opcodes
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_SYSTEM = 7'h73;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;

   // ALU funct3
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // branch funct3
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // result transfer layout
   localparam int RSP_W         = 80;
   localparam int RSP_IDX_LSB   = 32;
   localparam int RSP_VAL_LSB   = 37;
   localparam int RSP_WR_BIT    = 69;
   localparam int RSP_TAKEN_BIT = 70;
   localparam int RSP_HALT_BIT  = 71;
   localparam int RSP_ILL_BIT   = 72;
   localparam int RSP_PAD_W     = 7;

   typedef struct packed {
      logic                      en;
      logic [RVX_REG_ADDR_W-1:0] addr;
      logic [RVX_XLEN-1:0]       data;
   } rf_wr_type;

   typedef struct packed {
      logic [RVX_XLEN-1:0]       next_pc;
      logic                      rd_en;
      logic [RVX_REG_ADDR_W-1:0] rd;
      logic [RVX_XLEN-1:0]       value;
      logic                      taken;
      logic                      illegal;
      logic                      halted;
      logic                      halt_set;
   } exec_res_type;

endpackage

`default_nettype wire

// File: hw/rtl/rvx_regfile.sv
// Integer register file: two registered read ports, one write port, bypass.
// Depends on rvx_pkg. Reset clears all entries at once through valid bits.
`timescale 1ns / 1ps
`default_nettype none

module rvx_regfile #(
   parameter int REGISTER_COUNT = rvx_pkg::RVX_REGISTER_COUNT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              rd_en,
   input  wire logic [rvx_pkg::RVX_REG_ADDR_W-1:0] raddr1,
   input  wire logic [rvx_pkg::RVX_REG_ADDR_W-1:0] raddr2,
   input  wire rvx_pkg::rf_wr_type                wr_port,
   output logic      [rvx_pkg::RVX_XLEN-1:0]      rdata1,
   output logic      [rvx_pkg::RVX_XLEN-1:0]      rdata2
);
   import rvx_pkg::*;

   localparam int IDX_W = $clog2(REGISTER_COUNT);
   localparam logic [RVX_REG_ADDR_W:0] REG_LIMIT = (RVX_REG_ADDR_W+1)'(REGISTER_COUNT);

   logic [RVX_XLEN-1:0]       mem_ff [REGISTER_COUNT];
   logic [REGISTER_COUNT-1:0] valid_ff;
   logic [RVX_XLEN-1:0]       q1_ff, q2_ff, byp_data_ff;
   logic                      byp1_ff, byp2_ff, zero1_ff, zero2_ff;

   logic [IDX_W-1:0] ra1_idx, ra2_idx, wa_idx;
   logic             zero1_in, zero2_in, byp1_in, byp2_in;

   assign ra1_idx = raddr1[IDX_W-1:0];
   assign ra2_idx = raddr2[IDX_W-1:0];
   assign wa_idx  = wr_port.addr[IDX_W-1:0];

   assign zero1_in = (raddr1 == '0) || ({1'b0, raddr1} >= REG_LIMIT) || !valid_ff[ra1_idx];
   assign zero2_in = (raddr2 == '0) || ({1'b0, raddr2} >= REG_LIMIT) || !valid_ff[ra2_idx];
   // write enable already excludes x0 and out-of-range registers
   assign byp1_in  = wr_port.en && (wr_port.addr == raddr1);
   assign byp2_in  = wr_port.en && (wr_port.addr == raddr2);

   always_ff @(posedge clock) begin
      if (wr_port.en) begin
         mem_ff[wa_idx] <= wr_port.data;
      end
      if (rd_en) begin
         q1_ff       <= mem_ff[ra1_idx];
         q2_ff       <= mem_ff[ra2_idx];
         byp_data_ff <= wr_port.data;
         byp1_ff     <= byp1_in;
         byp2_ff     <= byp2_in;
         zero1_ff    <= zero1_in;
         zero2_ff    <= zero2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_port.en) begin
         valid_ff[wa_idx] <= 1'b1;
      end
   end

   assign rdata1 = byp1_ff ? byp_data_ff : (zero1_ff ? '0 : q1_ff);
   assign rdata2 = byp2_ff ? byp_data_ff : (zero2_ff ? '0 : q2_ff);

endmodule

`default_nettype wire

// File: hw/rtl/rvx_exec.sv
// Instruction decode, ALU, branch compare and next-PC logic.
// Depends on rvx_pkg. Purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module rvx_exec (
   input  wire logic [rvx_pkg::RVX_XLEN-1:0] instr,
   input  wire logic [rvx_pkg::RVX_XLEN-1:0] pc,
   input  wire logic [rvx_pkg::RVX_XLEN-1:0] rs1_val,
   input  wire logic [rvx_pkg::RVX_XLEN-1:0] rs2_val,
   input  wire logic                          halt_in,
   output rvx_pkg::exec_res_type              res
);
   import rvx_pkg::*;

   logic [6:0]          opc, f7;
   logic [2:0]          f3;
   logic [RVX_XLEN-1:0] immi, immb, immj, immu, y, alu, pc_plus4;
   logic [4:0]          shamt;
   logic                alt, is_reg, bad_f7, cond, br_ill;

   assign opc      = instr[6:0];
   assign f3       = instr[14:12];
   assign f7       = instr[31:25];
   assign immi     = {{20{instr[31]}}, instr[31:20]};
   assign immb     = {{20{instr[31]}}, instr[7], instr[30:25], instr[11:8], 1'b0};
   assign immj     = {{12{instr[31]}}, instr[19:12], instr[20], instr[30:21], 1'b0};
   assign immu     = {instr[31:12], 12'h000};
   assign pc_plus4 = pc + 32'd4;

   assign is_reg = (opc == OP_REG);
   assign y      = is_reg ? rs2_val : immi;
   assign shamt  = y[4:0];
   assign alt    = is_reg ? (f7 == F7_ALT) : instr[30];
   assign bad_f7 = is_reg && ((f3 == F3_ADD) || (f3 == F3_SR))
                   && (f7 != F7_BASE) && (f7 != F7_ALT);

   always_comb begin
      case (f3)
         F3_ADD:  alu = (is_reg && alt) ? (rs1_val - y) : (rs1_val + y);
         F3_SLL:  alu = rs1_val << shamt;
         F3_SLT:  alu = {31'd0, $signed(rs1_val) < $signed(y)};
         F3_SLTU: alu = {31'd0, rs1_val < y};
         F3_XOR:  alu = rs1_val ^ y;
         F3_SR:   alu = alt ? RVX_XLEN'($signed(rs1_val) >>> shamt) : (rs1_val >> shamt);
         F3_OR:   alu = rs1_val | y;
         default: alu = rs1_val & y;
      endcase
   end

   always_comb begin
      br_ill = 1'b0;
      case (f3)
         F3_BEQ:  cond = (rs1_val == rs2_val);
         F3_BNE:  cond = (rs1_val != rs2_val);
         F3_BLT:  cond = $signed(rs1_val) < $signed(rs2_val);
         F3_BGE:  cond = $signed(rs1_val) >= $signed(rs2_val);
         F3_BLTU: cond = rs1_val < rs2_val;
         F3_BGEU: cond = rs1_val >= rs2_val;
         default: begin
            cond   = 1'b0;
            br_ill = 1'b1;
         end
      endcase
   end

   always_comb begin
      res          = '0;
      res.next_pc  = pc_plus4;
      res.rd       = instr[11:7];
      res.halted   = halt_in;
      if (halt_in) begin
         res.next_pc = pc;
      end else begin
         unique case (opc)
            OP_REG, OP_IMM: begin
               res.illegal = bad_f7;
               res.rd_en   = !bad_f7;
               res.value   = alu;
            end
            OP_STORE: ;
            OP_LUI: begin
               res.rd_en = 1'b1;
               res.value = immu;
            end
            OP_AUIPC: begin
               res.rd_en = 1'b1;
               res.value = pc + immu;
            end
            OP_SYSTEM: begin
               res.halt_set = 1'b1;
               res.halted   = 1'b1;
               res.next_pc  = pc;
            end
            OP_BRANCH: begin
               res.illegal = br_ill;
               res.taken   = cond;
               if (cond) begin
                  res.next_pc = pc + immb;
               end
            end
            OP_JAL: begin
               res.rd_en   = 1'b1;
               res.value   = pc_plus4;
               res.taken   = 1'b1;
               res.next_pc = pc + immj;
            end
            OP_JALR: begin
               res.rd_en   = 1'b1;
               res.value   = pc_plus4;
               res.taken   = 1'b1;
               res.next_pc = (rs1_val + immi) & 32'hFFFF_FFFE;
            end
            default: res.illegal = 1'b1;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/rv32i_integer_execute_step_top.sv
// RV32I execute step, top level: handshake, execute register, PC, halt, result register.
// Depends on rvx_pkg, rvx_regfile and rvx_exec.
//
// Each transfer on req_ carries one instruction word fetched at the core's current PC;
// each instruction yields exactly one transfer on rsp_. An instruction is captured in
// the execute register on acceptance while its source registers are read; when the result
// register can take it, it retires there and updates the register file, PC and halt flag.
// One instruction is taken every cycle while rsp_tready is high, the result register
// decoupling the two sides; rsp_ stalls can hold req_tready low. That rate is set by the
// path from the registered register-file read (with write bypass) through the ALU and the
// next-PC adders. After reset the register file reads as zero at once; no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module rv32i_integer_execute_step_top #(
   parameter int REGISTER_COUNT = rvx_pkg::RVX_REGISTER_COUNT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [31:0]                req_tdata,  // [31:0] instr_word
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // [31:0] next_pc, [36:32] dest_index, [68:37] dest_value, [69] dest_written,
   // [70] branch_taken, [71] halted, [72] illegal, [79:73] zero
   output logic [rvx_pkg::RSP_W-1:0]       rsp_tdata
);
   import rvx_pkg::*;

   logic                ex_valid_ff, ex_valid_in;
   logic [RVX_XLEN-1:0] ex_instr_ff;
   logic [RVX_XLEN-1:0] pc_ff, pc_in;
   logic                halt_ff, halt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                req_fire, ex_fire, rd_ok;
   logic [RVX_XLEN-1:0] rs1_val, rs2_val;
   exec_res_type        res;
   rf_wr_type           wr_port;

   localparam logic [RVX_REG_ADDR_W:0] REG_LIMIT = (RVX_REG_ADDR_W+1)'(REGISTER_COUNT);

   assign ex_fire    = ex_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !ex_valid_ff || ex_fire;
   assign req_fire   = req_tvalid && req_tready;

   rvx_regfile #(
      .REGISTER_COUNT(REGISTER_COUNT)
   ) u_regfile (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (req_fire),
      .raddr1 (req_tdata[19:15]),
      .raddr2 (req_tdata[24:20]),
      .wr_port(wr_port),
      .rdata1 (rs1_val),
      .rdata2 (rs2_val)
   );

   rvx_exec u_exec (
      .instr  (ex_instr_ff),
      .pc     (pc_ff),
      .rs1_val(rs1_val),
      .rs2_val(rs2_val),
      .halt_in(halt_ff),
      .res    (res)
   );

   assign rd_ok        = res.rd_en && (res.rd != '0) && ({1'b0, res.rd} < REG_LIMIT);
   assign wr_port.en   = ex_fire && rd_ok;
   assign wr_port.addr = res.rd;
   assign wr_port.data = res.value;

   assign ex_valid_in  = req_fire ? 1'b1 : (ex_fire ? 1'b0 : ex_valid_ff);
   assign rsp_valid_in = ex_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign pc_in        = ex_fire ? res.next_pc : pc_ff;
   assign halt_in      = halt_ff || (ex_fire && res.halt_set);

   assign rsp_data_in = {
      {RSP_PAD_W{1'b0}},
      res.illegal,
      res.halted,
      res.taken,
      rd_ok,
      (rd_ok ? res.value : {RVX_XLEN{1'b0}}),
      (rd_ok ? res.rd : {RVX_REG_ADDR_W{1'b0}}),
      res.next_pc
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ex_instr_ff <= req_tdata;
      end
      if (ex_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rvx_checker.sv
// Port-level checker for the execute step top level, bound to it below.
// Depends on rvx_pkg and rv32i_integer_execute_step_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "rv32i_integer_execute_step_top_assert.svh"

module rvx_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [rvx_pkg::RSP_W-1:0]  rsp_tdata
);
   import rvx_pkg::*;

   logic seen_halt_ff;
   logic wr_bit, taken_bit, halt_bit, ill_bit;
   logic [RVX_REG_ADDR_W-1:0] idx;
   logic [RVX_XLEN-1:0]       val;

   assign wr_bit    = rsp_tdata[RSP_WR_BIT];
   assign taken_bit = rsp_tdata[RSP_TAKEN_BIT];
   assign halt_bit  = rsp_tdata[RSP_HALT_BIT];
   assign ill_bit   = rsp_tdata[RSP_ILL_BIT];
   assign idx       = rsp_tdata[RSP_IDX_LSB +: RVX_REG_ADDR_W];
   assign val       = rsp_tdata[RSP_VAL_LSB +: RVX_XLEN];

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && halt_bit) begin
         seen_halt_ff <= 1'b1;
      end
   end

   // once halted, every later transfer is an inert halted one
   `RVX_ASSERT_IMPL(a_halt_sticky, clock, reset, rsp_tvalid && seen_halt_ff, halt_bit && !wr_bit && !taken_bit && !ill_bit, "transfer after halt is not inert")
   `RVX_ASSERT_IMPL(a_no_write_zero, clock, reset, rsp_tvalid && !wr_bit, (idx == '0) && (val == '0), "destination fields set without a write")
   `RVX_ASSERT_IMPL(a_write_not_x0, clock, reset, rsp_tvalid && wr_bit, (idx != '0) && !ill_bit, "write to x0 or on illegal instruction")
   `RVX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

bind rv32i_integer_execute_step_top rvx_checker u_rvx_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

`default_nettype wire

// File: bench/rv32i_integer_execute_step_top_tb.sv
// Self-checking bench for rv32i_integer_execute_step_top: a shadow RV32I core predicts each
// retired instruction, and directed and random instruction streams run under varied back-pressure.
// Depends on rvx_pkg and the execute step RTL only.
`timescale 1ns / 1ps

module rv32i_integer_execute_step_top_tb;
   import rvx_pkg::*;

   localparam int REG_COUNT    = RVX_REGISTER_COUNT;
   localparam int BURST_CYCLES = 64;
   localparam int PHASE_ITEMS  = 205;
   localparam logic [2:0] F3_BR_UNUSED = 3'd3;

   typedef struct {
      logic [31:0] next_pc;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic        dest_written;
      logic        branch_taken;
      logic        halted;
      logic        illegal;
   } retire_type;

   class rv32i_shadow_core_type;
      logic [31:0] regs [32];
      logic [31:0] pc;
      bit          halted;
      retire_type  retire_q [$];
      int unsigned mismatches;

      function new();
         foreach (regs[i]) regs[i] = '0;
         pc = '0;
         halted = 1'b0;
         mismatches = 0;
      endfunction

      function logic [31:0] src(logic [4:0] idx);
         if (idx == 0 || idx >= REG_COUNT) return '0;
         return regs[idx];
      endfunction

      function int unsigned outstanding();
         return retire_q.size();
      endfunction

      // executes one accepted instruction and queues what it retires
      function void fetch_accepted(logic [31:0] w);
         logic [6:0]  opc;
         logic [4:0]  rd;
         logic [2:0]  f3;
         logic [6:0]  f7;
         logic [31:0] a, b, y, immi, immb, immj, npc, val;
         logic        wr, taken, ill, alt;
         retire_type  r;
         opc  = w[6:0];
         rd   = w[11:7];
         f3   = w[14:12];
         f7   = w[31:25];
         a    = src(w[19:15]);
         b    = src(w[24:20]);
         immi = {{20{w[31]}}, w[31:20]};
         immb = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
         immj = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
         npc  = pc + 32'd4;
         val  = '0;
         wr   = 1'b0;
         taken = 1'b0;
         ill  = 1'b0;
         if (halted) begin
            npc = pc;
         end else begin
            case (opc)
               OP_REG, OP_IMM: begin
                  y   = (opc == OP_REG) ? b : immi;
                  alt = (opc == OP_REG) ? (f7 == F7_ALT) : w[30];
                  if (opc == OP_REG && (f3 == F3_ADD || f3 == F3_SR)
                      && f7 != F7_BASE && f7 != F7_ALT) begin
                     ill = 1'b1;
                  end else begin
                     wr = 1'b1;
                     case (f3)
                        F3_ADD:  val = (opc == OP_REG && alt) ? a - y : a + y;
                        F3_SLL:  val = a << y[4:0];
                        F3_SLT:  val = {31'd0, $signed(a) < $signed(y)};
                        F3_SLTU: val = {31'd0, a < y};
                        F3_XOR:  val = a ^ y;
                        F3_SR: begin
                           if (alt) val = $signed(a) >>> y[4:0];
                           else     val = a >> y[4:0];
                        end
                        F3_OR:   val = a | y;
                        default: val = a & y;
                     endcase
                  end
               end
               OP_STORE: ;
               OP_LUI: begin
                  wr = 1'b1;
                  val = {w[31:12], 12'd0};
               end
               OP_AUIPC: begin
                  wr = 1'b1;
                  val = pc + {w[31:12], 12'd0};
               end
               OP_SYSTEM: begin
                  halted = 1'b1;
                  npc = pc;
               end
               OP_BRANCH: begin
                  case (f3)
                     F3_BEQ:  taken = (a == b);
                     F3_BNE:  taken = (a != b);
                     F3_BLT:  taken = $signed(a) < $signed(b);
                     F3_BGE:  taken = $signed(a) >= $signed(b);
                     F3_BLTU: taken = a < b;
                     F3_BGEU: taken = a >= b;
                     default: ill = 1'b1;
                  endcase
                  if (taken) npc = pc + immb;
               end
               OP_JAL: begin
                  wr = 1'b1;
                  val = pc + 32'd4;
                  taken = 1'b1;
                  npc = pc + immj;
               end
               OP_JALR: begin
                  wr = 1'b1;
                  val = pc + 32'd4;
                  taken = 1'b1;
                  npc = a + immi;
                  npc[0] = 1'b0;
               end
               default: ill = 1'b1;
            endcase
         end
         if (wr && (rd == 0 || rd >= REG_COUNT)) wr = 1'b0;
         if (wr) regs[rd] = val;
         pc = npc;
         r.next_pc      = npc;
         r.dest_index   = wr ? rd : 5'd0;
         r.dest_value   = wr ? val : 32'd0;
         r.dest_written = wr;
         r.branch_taken = taken;
         r.halted       = halted;
         r.illegal      = ill;
         retire_q.push_back(r);
      endfunction

      function void match_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
         end
      endfunction

      function void retire_check(logic [RSP_W-1:0] d);
         retire_type e;
         if (retire_q.size() == 0) begin
            $error("rsp transfer %h with no instruction outstanding", d);
            mismatches++;
            return;
         end
         e = retire_q.pop_front();
         match_field("next_pc", e.next_pc, d[31:0]);
         match_field("dest_index", 32'(e.dest_index), 32'(d[RSP_IDX_LSB +: 5]));
         match_field("dest_value", e.dest_value, d[RSP_VAL_LSB +: 32]);
         match_field("dest_written", 32'(e.dest_written), 32'(d[RSP_WR_BIT]));
         match_field("branch_taken", 32'(e.branch_taken), 32'(d[RSP_TAKEN_BIT]));
         match_field("halted", 32'(e.halted), 32'(d[RSP_HALT_BIT]));
         match_field("illegal", 32'(e.illegal), 32'(d[RSP_ILL_BIT]));
         match_field("padding", 32'd0, 32'(d[RSP_W-1 -: RSP_PAD_W]));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;   // [31:0] instr_word
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // [31:0] next_pc, [36:32] dest_index, [68:37] dest_value, [69] dest_written,
   // [70] branch_taken, [71] halted, [72] illegal, [79:73] zero
   logic [RSP_W-1:0]  rsp_tdata;

   rv32i_shadow_core_type core = new();
   int unsigned send_idle  = 0;
   int unsigned recv_stall = 0;
   bit          burst_req  = 1'b0;

   rv32i_integer_execute_step_top #(.REGISTER_COUNT(REG_COUNT)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result first, so a transfer never meets its own instruction's expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) core.retire_check(rsp_tdata);
         if (req_tvalid && req_tready) core.fetch_accepted(req_tdata);
      end
   end

   // receiver: random stalls, or a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (burst_req) begin
            burst_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (BURST_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall);
         end
      end
   end

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OP_REG};
   endfunction

   function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] op);
      return {imm, rd, op};
   endfunction

   function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
   endfunction

   function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
   endfunction

   // mostly well-formed instructions with random fields; never ECALL
   function automatic logic [31:0] random_instr();
      int unsigned pick;
      logic [31:0] w;
      logic [11:0] imm;
      logic [6:0]  f7;
      logic [6:0]  op;
      pick = $urandom_range(0, 99);
      w = $urandom;
      if (pick < 30) begin
         if ($urandom_range(0, 9) == 0) f7 = 7'($urandom);
         else                          f7 = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
         w = {f7, w[24:7], OP_REG};
      end else if (pick < 55) begin
         imm = w[31:20];
         if ((w[14:12] == F3_SLL || w[14:12] == F3_SR) && $urandom_range(0, 3) != 0)
            imm[11:5] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
         w = {imm, w[19:7], OP_IMM};
      end else if (pick < 63) begin
         w[6:0] = OP_LUI;
      end else if (pick < 67) begin
         w[6:0] = OP_AUIPC;
      end else if (pick < 79) begin
         if ($urandom_range(0, 3) == 0) w[24:20] = w[19:15];
         w[6:0] = OP_BRANCH;
      end else if (pick < 84) begin
         w[6:0] = OP_JAL;
      end else if (pick < 89) begin
         w[6:0] = OP_JALR;
      end else if (pick < 93) begin
         w[6:0] = OP_STORE;
      end else if (pick < 97) begin
         do op = 7'($urandom);
         while (op inside {OP_REG, OP_IMM, OP_STORE, OP_LUI, OP_SYSTEM, OP_AUIPC,
                           OP_BRANCH, OP_JAL, OP_JALR});
         w[6:0] = op;
      end else begin
         while (w[6:0] == OP_SYSTEM) w = $urandom;
      end
      return w;
   endfunction

   // valid stays high into the next call unless the sender idles
   task automatic send_instr(input logic [31:0] w);
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_retired();
      do @(posedge clock);
      while (core.outstanding() != 0);
   endtask

   initial begin
      int unsigned send_pct [4];
      int unsigned recv_pct [4];
      send_pct = '{0, 74, 0, 25};
      recv_pct = '{0, 0, 74, 25};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // operand extremes, each ALU operation, the x0 and funct7 rules, branch and jump limits
      send_instr(enc_u(20'h80000, 5'd1, OP_LUI));
      send_instr(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, OP_IMM));
      send_instr(enc_i(12'hFFF, 5'd1, F3_ADD, 5'd3, OP_IMM));
      send_instr(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd0));
      send_instr(enc_r(F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd4));
      send_instr(enc_r(F7_BASE, 5'd2, 5'd2, F3_SLL, 5'd5));
      send_instr(enc_r(F7_ALT, 5'd3, 5'd1, F3_SR, 5'd6));
      send_instr(enc_r(F7_BASE, 5'd3, 5'd1, F3_SR, 5'd7));
      send_instr(enc_r(F7_BASE, 5'd3, 5'd1, F3_SLT, 5'd8));
      send_instr(enc_r(F7_BASE, 5'd3, 5'd1, F3_SLTU, 5'd9));
      send_instr(enc_r(7'h01, 5'd2, 5'd1, F3_ADD, 5'd10));
      send_instr(enc_r(7'h7F, 5'd2, 5'd3, F3_XOR, 5'd11));
      send_instr(enc_r(7'h7F, 5'd3, 5'd1, F3_OR, 5'd12));
      send_instr(enc_i(12'h41F, 5'd1, F3_SR, 5'd13, OP_IMM));
      send_instr(enc_i(12'hFFF, 5'd2, F3_SLTU, 5'd14, OP_IMM));
      send_instr(enc_i(12'h7FF, 5'd2, F3_AND, 5'd31, OP_IMM));
      send_instr(enc_u(20'hFFFFF, 5'd15, OP_AUIPC));
      send_instr(enc_b(13'h1000, 5'd1, 5'd1, F3_BEQ));
      send_instr(enc_b(13'h0FFE, 5'd0, 5'd0, F3_BNE));
      send_instr(enc_b(13'h0008, 5'd3, 5'd1, F3_BLT));
      send_instr(enc_b(13'h0FFE, 5'd1, 5'd2, F3_BGEU));
      send_instr(enc_b(13'h0010, 5'd2, 5'd1, F3_BR_UNUSED));
      send_instr(enc_j(21'h100000, 5'd16));
      send_instr(enc_j(21'h0FFFFE, 5'd0));
      send_instr(enc_i(12'h7FF, 5'd2, 3'($urandom), 5'd17, OP_JALR));
      send_instr({25'($urandom), OP_STORE});
      send_instr(32'hFFFF_FFFF);
      send_instr(32'h0000_0000);

      for (int p = 0; p < 4; p++) begin
         send_idle  = send_pct[p];
         recv_stall = recv_pct[p];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // long hold-off while the sender keeps offering
            if (p == 0 && i == 40) burst_req = 1'b1;
            send_instr(random_instr());
         end
         req_tvalid <= 1'b0;
         wait_retired();
      end

      // halt, then a few instructions on the stopped core
      send_idle  = 0;
      recv_stall = 25;
      send_instr({25'($urandom), OP_SYSTEM});
      repeat (3) send_instr(random_instr());
      send_instr({25'($urandom), OP_SYSTEM});
      send_instr(32'hFFFF_FFFF);
      send_instr(enc_j(21'h000010, 5'd1));
      req_tvalid <= 1'b0;
      wait_retired();
      repeat (8) @(posedge clock);
      if (core.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
